// File: rtl/core/adp_pkg.sv
// ----------------------------------------------------------------------------
// adp_pkg
// Shared types, constants and helpers of the ArtDMX frame parser.
// ----------------------------------------------------------------------------
package adp_pkg;

  localparam int ADP_CHANNELS       = 512;
  localparam int ADP_PAYLOAD_OFFSET = 42;
  localparam int ADP_PORT_OFFSET    = 36;

  localparam int POS_W    = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 16;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_PORT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WANTED_OPCODE = 1'd1;

  localparam logic [15:0] LISTEN_PORT_RST   = 16'd6454;
  localparam logic [15:0] WANTED_OPCODE_RST = 16'h5000;

  localparam int IDENT_LEN = 7;

  localparam logic [POS_W-1:0] OFS_OPCODE_LO  = POS_W'(8);
  localparam logic [POS_W-1:0] OFS_OPCODE_HI  = POS_W'(9);
  localparam logic [POS_W-1:0] OFS_VERSION_HI = POS_W'(10);
  localparam logic [POS_W-1:0] OFS_VERSION_LO = POS_W'(11);
  localparam logic [POS_W-1:0] OFS_SEQUENCE   = POS_W'(12);
  localparam logic [POS_W-1:0] OFS_PHYSICAL   = POS_W'(13);
  localparam logic [POS_W-1:0] OFS_UNIVERSE_LO = POS_W'(14);
  localparam logic [POS_W-1:0] OFS_UNIVERSE_HI = POS_W'(15);
  localparam logic [POS_W-1:0] OFS_LENGTH_HI  = POS_W'(16);
  localparam logic [POS_W-1:0] OFS_LENGTH_LO  = POS_W'(17);
  localparam int               OFS_DATA       = 18;

  localparam logic ITEM_DATA    = 1'b0;
  localparam logic ITEM_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [8:0]  channel_index;
    logic [7:0]  channel_value;
    logic        accepted;
    logic [15:0] universe;
    logic [15:0] data_length;
    logic [7:0]  sequence_res;
    logic [7:0]  physical_port;
    logic [15:0] protocol_version;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic        has_data;
    logic        has_sum;
    logic [8:0]  channel_index;
    logic [7:0]  channel_value;
    logic        accepted;
    logic [15:0] universe;
    logic [15:0] data_length;
    logic [7:0]  sequence_res;
    logic [7:0]  physical_port;
    logic [15:0] protocol_version;
  } job_t;

  typedef enum logic {
    BK_DATA,
    BK_SUM
  } back_state_t;

  function automatic logic [7:0] ident_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h41;
      3'd1:    b = 8'h72;
      3'd2:    b = 8'h74;
      3'd3:    b = 8'h2D;
      3'd4:    b = 8'h4E;
      3'd5:    b = 8'h65;
      3'd6:    b = 8'h74;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/adp_front.sv
// ----------------------------------------------------------------------------
// adp_front
// Counts byte positions, captures the header fields, checks the packet and
// pushes one job per byte that causes results.
// ----------------------------------------------------------------------------
module adp_front import adp_pkg::*; #(
  parameter int CHANNELS       = ADP_CHANNELS,
  parameter int PAYLOAD_OFFSET = ADP_PAYLOAD_OFFSET,
  parameter int PORT_OFFSET    = ADP_PORT_OFFSET
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  in_item_t             in_data,
  output logic                 in_ready,
  input  logic                 q_full,
  output logic                 q_push,
  output job_t                 q_job
);

  localparam int DATA_START = PAYLOAD_OFFSET + OFS_DATA;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  logic [15:0]      listen_port_r;
  logic [15:0]      wanted_opcode_r;
  logic [POS_W-1:0] pos_r;
  logic [15:0]      port_r, opcode_r, version_r, univ_r, len_r;
  logic [7:0]       seq_r, phys_r;
  logic             ident_r;

  logic [POS_W-1:0] p, rel;
  logic [15:0]      port_nxt, opcode_nxt, version_nxt, univ_nxt, len_nxt;
  logic [7:0]       seq_nxt, phys_nxt;
  logic             ident_nxt;
  logic             complete, match, emit_data, accept;
  logic [7:0]       b;

  assign b        = in_data.frame_byte;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    p           = in_data.frame_start ? '0 : pos_r;
    port_nxt    = in_data.frame_start ? '0 : port_r;
    opcode_nxt  = in_data.frame_start ? '0 : opcode_r;
    version_nxt = in_data.frame_start ? '0 : version_r;
    univ_nxt    = in_data.frame_start ? '0 : univ_r;
    len_nxt     = in_data.frame_start ? '0 : len_r;
    seq_nxt     = in_data.frame_start ? '0 : seq_r;
    phys_nxt    = in_data.frame_start ? '0 : phys_r;
    ident_nxt   = in_data.frame_start ? 1'b1 : ident_r;
    rel         = p - POS_W'(PAYLOAD_OFFSET);

    if (p == POS_W'(PORT_OFFSET)) begin
      port_nxt[15:8] = b;
    end
    if (p == POS_W'(PORT_OFFSET + 1)) begin
      port_nxt[7:0] = b;
    end

    if (p >= POS_W'(PAYLOAD_OFFSET)) begin
      if (rel < POS_W'(IDENT_LEN)) begin
        if (b != ident_byte(rel[2:0])) begin
          ident_nxt = 1'b0;
        end
      end else begin
        unique case (rel)
          OFS_OPCODE_LO:   opcode_nxt[7:0]   = b;
          OFS_OPCODE_HI:   opcode_nxt[15:8]  = b;
          OFS_VERSION_HI:  version_nxt[15:8] = b;
          OFS_VERSION_LO:  version_nxt[7:0]  = b;
          OFS_SEQUENCE:    seq_nxt           = b;
          OFS_PHYSICAL:    phys_nxt          = b;
          OFS_UNIVERSE_LO: univ_nxt[7:0]     = b;
          OFS_UNIVERSE_HI: univ_nxt[15:8]    = b;
          OFS_LENGTH_HI:   len_nxt[15:8]     = b;
          OFS_LENGTH_LO:   len_nxt[7:0]      = b;
          default: begin
          end
        endcase
      end
    end

    complete  = (p >= POS_W'(PAYLOAD_OFFSET + 9)) && (p >= POS_W'(PORT_OFFSET + 1));
    match     = complete && ident_nxt && (port_nxt == listen_port_r) &&
                (opcode_nxt == wanted_opcode_r);
    emit_data = match && (p >= POS_W'(DATA_START)) &&
                ((p - POS_W'(DATA_START)) < POS_W'(CHANNELS));
  end

  always_comb begin
    q_push                 = accept && (emit_data || in_data.frame_end);
    q_job.has_data         = emit_data;
    q_job.has_sum          = in_data.frame_end;
    q_job.channel_index    = 9'(p - POS_W'(DATA_START));
    q_job.channel_value    = b;
    q_job.accepted         = match;
    q_job.universe         = univ_nxt;
    q_job.data_length      = len_nxt;
    q_job.sequence_res     = seq_nxt;
    q_job.physical_port    = phys_nxt;
    q_job.protocol_version = version_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_port_r   <= LISTEN_PORT_RST;
      wanted_opcode_r <= WANTED_OPCODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LISTEN_PORT:   listen_port_r   <= cfg_data[15:0];
        CFG_WANTED_OPCODE: wanted_opcode_r <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      port_r    <= '0;
      opcode_r  <= '0;
      version_r <= '0;
      univ_r    <= '0;
      len_r     <= '0;
      seq_r     <= '0;
      phys_r    <= '0;
      ident_r   <= 1'b1;
    end else if (accept) begin
      if (in_data.frame_end) begin
        pos_r     <= '0;
        port_r    <= '0;
        opcode_r  <= '0;
        version_r <= '0;
        univ_r    <= '0;
        len_r     <= '0;
        seq_r     <= '0;
        phys_r    <= '0;
        ident_r   <= 1'b1;
      end else begin
        pos_r     <= (p == POS_MAX) ? POS_MAX : p + POS_W'(1);
        port_r    <= port_nxt;
        opcode_r  <= opcode_nxt;
        version_r <= version_nxt;
        univ_r    <= univ_nxt;
        len_r     <= len_nxt;
        seq_r     <= seq_nxt;
        phys_r    <= phys_nxt;
        ident_r   <= ident_nxt;
      end
    end
  end

endmodule

// File: rtl/core/adp_queue.sv
// ----------------------------------------------------------------------------
// adp_queue
// Short first-in first-out queue of jobs between the parser and the emitter.
// ----------------------------------------------------------------------------
module adp_queue import adp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/core/adp_back.sv
// ----------------------------------------------------------------------------
// adp_back
// Expands each job into its data and summary results and holds them in the
// output register until taken.
// ----------------------------------------------------------------------------
module adp_back import adp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  job_t      q_job,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  back_state_t state_r, state_nxt;
  logic        out_valid_r;
  out_item_t   out_data_r, cand;
  logic        load, take, send_data;

  assign load      = !out_valid_r || out_ready;
  assign take      = q_valid && load;
  assign send_data = q_job.has_data && (state_r == BK_DATA);

  always_comb begin
    state_nxt = state_r;
    if (take) begin
      if (send_data && q_job.has_sum) begin
        state_nxt = BK_SUM;
      end else begin
        state_nxt = BK_DATA;
      end
    end
  end

  always_comb begin
    cand = '0;
    if (send_data) begin
      cand.item_kind     = ITEM_DATA;
      cand.channel_index = q_job.channel_index;
      cand.channel_value = q_job.channel_value;
      cand.last_of_run   = !q_job.has_sum;
      q_pop              = take && !q_job.has_sum;
    end else begin
      cand.item_kind        = ITEM_SUMMARY;
      cand.accepted         = q_job.accepted;
      cand.universe         = q_job.universe;
      cand.data_length      = q_job.data_length;
      cand.sequence_res     = q_job.sequence_res;
      cand.physical_port    = q_job.physical_port;
      cand.protocol_version = q_job.protocol_version;
      cand.last_of_run      = 1'b1;
      q_pop                 = take;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_DATA;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= cand;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/artdmx_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// artdmx_frame_parser_unit
// ArtDMX packet parser for a received Ethernet/IPv4/UDP byte stream.
// ----------------------------------------------------------------------------
// The unit takes one frame byte per clock and keeps taking one per clock as
// long as its four-entry job queue has room. A byte inside the DMX data window
// of a matching packet yields one channel result, and the byte flagged as
// frame end yields a summary result. Results leave through a registered
// output at one per clock while the output is not stalled, so a frame-end
// byte that also carries a channel yields its two results in turn; the job
// queue absorbs the delay. Configuration writes take effect on the next
// clock and should only be made while no frame is in progress.
module artdmx_frame_parser_unit import adp_pkg::*; #(
  parameter int CHANNELS       = ADP_CHANNELS,
  parameter int PAYLOAD_OFFSET = ADP_PAYLOAD_OFFSET,
  parameter int PORT_OFFSET    = ADP_PORT_OFFSET
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  logic q_full, q_push, q_pop, q_valid;
  job_t push_job, head_job;

  adp_front #(
    .CHANNELS       (CHANNELS),
    .PAYLOAD_OFFSET (PAYLOAD_OFFSET),
    .PORT_OFFSET    (PORT_OFFSET)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  adp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  adp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: verif/artdmx_frame_parser_unit_test.sv
// ----------------------------------------------------------------------------
// artdmx_frame_parser_unit_test
// Self-checking testbench for the ArtDMX frame parser.
// ----------------------------------------------------------------------------
// Frames are fed as a stream of byte words. Most are well-formed Art-Net
// ArtDMX packets with random content. Some have a wrong port, a wrong opcode
// or a damaged identifier, some are pure noise, and some are cut short or
// restarted. A scoreboard predicts every channel and summary result and
// compares each result field by field, in order. Both sides stall in random
// bursts in all but the last phase. The listen port and opcode registers are
// swept over zero, all-ones, random and reset values between phases.
// ----------------------------------------------------------------------------
module artdmx_frame_parser_unit_test import adp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 9;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_WORDS = 260;
  localparam int DATA_BASE    = ADP_PAYLOAD_OFFSET + OFS_DATA;
  localparam logic [POS_W-1:0] POS_SAT   = '1;
  localparam logic [55:0]      ARTNET_ID = "Art-Net";

  class artdmx_scoreboard;
    logic [15:0]      listen_port;
    logic [15:0]      wanted_opcode;
    logic [POS_W-1:0] position;
    logic [15:0]      port_reg;
    logic [15:0]      opcode_reg;
    logic [15:0]      version_reg;
    logic [15:0]      universe_reg;
    logic [15:0]      length_reg;
    logic [7:0]       sequence_reg;
    logic [7:0]       physical_reg;
    logic             ident_ok;
    out_item_t        dmx_results_due[$];
    int               mismatches;
    int               words_seen;
    int               channels_checked;
    int               summaries_checked;
    int               accepted_frames;

    function new();
      listen_port       = LISTEN_PORT_RST;
      wanted_opcode     = WANTED_OPCODE_RST;
      mismatches        = 0;
      words_seen        = 0;
      channels_checked  = 0;
      summaries_checked = 0;
      accepted_frames   = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      position     = '0;
      port_reg     = '0;
      ident_ok     = 1'b1;
      opcode_reg   = '0;
      version_reg  = '0;
      sequence_reg = '0;
      physical_reg = '0;
      universe_reg = '0;
      length_reg   = '0;
    endfunction

    function void parse_frame_byte(in_item_t w);
      int        p;
      int        rel;
      logic [7:0] b;
      logic      complete;
      logic      hit;
      logic      has_channel;
      out_item_t channel_r;
      out_item_t summary_r;
      b = w.frame_byte;
      words_seen++;
      if (w.frame_start) begin
        clear_frame();
      end
      p = int'(position);
      if (p == ADP_PORT_OFFSET) begin
        port_reg[15:8] = b;
      end
      if (p == ADP_PORT_OFFSET + 1) begin
        port_reg[7:0] = b;
      end
      rel = p - ADP_PAYLOAD_OFFSET;
      if (rel >= 0 && rel < IDENT_LEN) begin
        if (b != ARTNET_ID[8*(IDENT_LEN-1-rel) +: 8]) begin
          ident_ok = 1'b0;
        end
      end else if (rel >= 0) begin
        case (rel)
          OFS_OPCODE_LO:   opcode_reg[7:0]    = b;
          OFS_OPCODE_HI:   opcode_reg[15:8]   = b;
          OFS_VERSION_HI:  version_reg[15:8]  = b;
          OFS_VERSION_LO:  version_reg[7:0]   = b;
          OFS_SEQUENCE:    sequence_reg       = b;
          OFS_PHYSICAL:    physical_reg       = b;
          OFS_UNIVERSE_LO: universe_reg[7:0]  = b;
          OFS_UNIVERSE_HI: universe_reg[15:8] = b;
          OFS_LENGTH_HI:   length_reg[15:8]   = b;
          OFS_LENGTH_LO:   length_reg[7:0]    = b;
          default: ;
        endcase
      end

      complete = p >= ADP_PAYLOAD_OFFSET + OFS_OPCODE_HI && p >= ADP_PORT_OFFSET + 1;
      hit = complete && ident_ok && port_reg == listen_port && opcode_reg == wanted_opcode;
      has_channel = hit && p >= DATA_BASE && p - DATA_BASE < ADP_CHANNELS;

      channel_r = '0;
      channel_r.item_kind     = ITEM_DATA;
      channel_r.channel_index = 9'(p - DATA_BASE);
      channel_r.channel_value = b;
      channel_r.last_of_run   = !w.frame_end;
      if (has_channel) begin
        dmx_results_due.push_back(channel_r);
      end

      if (w.frame_end) begin
        summary_r = '0;
        summary_r.item_kind        = ITEM_SUMMARY;
        summary_r.accepted         = hit;
        summary_r.universe         = universe_reg;
        summary_r.data_length      = length_reg;
        summary_r.sequence_res     = sequence_reg;
        summary_r.physical_port    = physical_reg;
        summary_r.protocol_version = version_reg;
        summary_r.last_of_run      = 1'b1;
        dmx_results_due.push_back(summary_r);
        clear_frame();
      end else if (position != POS_SAT) begin
        position = position + 1'b1;
      end
    endfunction

    function string show(out_item_t r);
      return $sformatf("kind=%0d ch=%0d val=%h acc=%0d uni=%h len=%h seq=%h phy=%h ver=%h last=%0d",
                       r.item_kind, r.channel_index, r.channel_value, r.accepted, r.universe,
                       r.data_length, r.sequence_res, r.physical_port, r.protocol_version,
                       r.last_of_run);
    endfunction

    function void check_result(out_item_t got);
      out_item_t due;
      string     diff;
      if (dmx_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with nothing pending: %s", $time, show(got));
        end
        return;
      end
      due = dmx_results_due.pop_front();
      diff = "";
      if (got.item_kind        !== due.item_kind)        diff = {diff, " item_kind"};
      if (got.channel_index    !== due.channel_index)    diff = {diff, " channel_index"};
      if (got.channel_value    !== due.channel_value)    diff = {diff, " channel_value"};
      if (got.accepted         !== due.accepted)         diff = {diff, " accepted"};
      if (got.universe         !== due.universe)         diff = {diff, " universe"};
      if (got.data_length      !== due.data_length)      diff = {diff, " data_length"};
      if (got.sequence_res     !== due.sequence_res)     diff = {diff, " sequence_res"};
      if (got.physical_port    !== due.physical_port)    diff = {diff, " physical_port"};
      if (got.protocol_version !== due.protocol_version) diff = {diff, " protocol_version"};
      if (got.last_of_run      !== due.last_of_run)      diff = {diff, " last_of_run"};
      if (diff != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: wrong%s", $time, diff);
          $display("  expected %s", show(due));
          $display("  actual   %s", show(got));
        end
      end else if (due.item_kind == ITEM_SUMMARY) begin
        summaries_checked++;
        if (due.accepted) begin
          accepted_frames++;
        end
      end else begin
        channels_checked++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;

  artdmx_scoreboard sb;
  int   gap_odds;
  int   stall_odds;
  int   quiet_cycles;
  int   words_driven;
  int   frames_sent;
  logic open_frame;

  artdmx_frame_parser_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
  end

  always #6ns clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.parse_frame_byte(in_data);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Timeout: %0d cycles without a word moving", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic s, input logic e);
    in_item_t w;
    w.frame_byte  = b;
    w.frame_start = s;
    w.frame_end   = e;
    @(negedge clk);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_driven++;
  endtask

  task automatic send_frame(input logic [7:0] pkt[$], input logic with_start,
                            input logic with_end, input int restart_at);
    for (int i = 0; i < pkt.size(); i++) begin
      send_word(pkt[i], (i == 0 && with_start) || i == restart_at,
                with_end && i == pkt.size() - 1);
    end
  endtask

  function automatic void build_packet(ref logic [7:0] pkt[$], input int len,
                                       input logic [15:0] port, input logic [15:0] opcode);
    logic [7:0] hdr [DATA_BASE];
    for (int i = 0; i < DATA_BASE; i++) begin
      hdr[i] = 8'($urandom);
    end
    hdr[ADP_PORT_OFFSET]     = port[15:8];
    hdr[ADP_PORT_OFFSET + 1] = port[7:0];
    for (int k = 0; k < IDENT_LEN; k++) begin
      hdr[ADP_PAYLOAD_OFFSET + k] = ARTNET_ID[8*(IDENT_LEN-1-k) +: 8];
    end
    hdr[ADP_PAYLOAD_OFFSET + OFS_OPCODE_LO] = opcode[7:0];
    hdr[ADP_PAYLOAD_OFFSET + OFS_OPCODE_HI] = opcode[15:8];
    pkt.delete();
    for (int i = 0; i < len; i++) begin
      pkt.push_back(i < DATA_BASE ? hdr[i] : 8'($urandom));
    end
  endfunction

  task automatic random_frame();
    logic [7:0]  pkt[$];
    logic [15:0] port;
    logic [15:0] opcode;
    logic        with_start;
    logic        with_end;
    int          kind;
    int          len;
    int          spot;
    int          restart_at;
    kind   = $urandom_range(0, 9);
    port   = sb.listen_port;
    opcode = sb.wanted_opcode;
    if (kind == 0) begin
      port = port ^ (16'd1 << $urandom_range(0, 15));
    end
    if (kind == 1) begin
      opcode = opcode ^ (16'd1 << $urandom_range(0, 15));
    end
    if ($urandom_range(0, 3) == 0) begin
      len = $urandom_range(1, DATA_BASE + 2);
    end else begin
      len = DATA_BASE + $urandom_range(0, 48);
    end
    build_packet(pkt, len, port, opcode);
    if (kind == 2) begin
      spot = ADP_PAYLOAD_OFFSET + $urandom_range(0, IDENT_LEN - 1);
      if (spot < len) begin
        pkt[spot] = pkt[spot] ^ (8'd1 << $urandom_range(0, 7));
      end
    end
    if (kind == 3) begin
      for (int i = 0; i < len; i++) begin
        pkt[i] = 8'($urandom);
      end
    end
    restart_at = $urandom_range(0, 9) == 0 ? $urandom_range(1, len) : -1;
    with_start = open_frame || $urandom_range(0, 7) != 0;
    with_end   = $urandom_range(0, 11) != 0;
    send_frame(pkt, with_start, with_end, restart_at);
    open_frame = !with_end;
    frames_sent++;
  endtask

  task automatic run_random(input int words);
    int target;
    target = words_driven + words;
    while (words_driven < target) begin
      random_frame();
    end
    if (open_frame) begin
      send_word(8'($urandom), 1'b0, 1'b1);
      open_frame = 1'b0;
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.dmx_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] port, input logic [15:0] opcode);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LISTEN_PORT;
    cfg_data  <= port;
    @(negedge clk);
    cfg_index <= CFG_WANTED_OPCODE;
    cfg_data  <= opcode;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.listen_port   = port;
    sb.wanted_opcode = opcode;
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_LISTEN_PORT;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    gap_odds     = 6;
    stall_odds   = 6;
    words_driven = 0;
    frames_sent  = 0;
    open_frame   = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // One-byte frames, a frame that follows an end without a start flag,
    // and a frame restarted in the middle.
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hFF, 1'b0, 1'b1);
    send_word(8'hA5, 1'b0, 1'b0);
    send_word(8'h5A, 1'b0, 1'b1);
    send_word(8'hAA, 1'b1, 1'b0);
    send_word(8'h55, 1'b0, 1'b0);
    send_word(8'h12, 1'b1, 1'b0);
    send_word(8'h34, 1'b0, 1'b0);
    send_word(8'h80, 1'b0, 1'b1);
    frames_sent += 5;

    run_random(RANDOM_WORDS);

    settle();
    set_config(16'h0000, 16'h0000);
    gap_odds   = 3;
    stall_odds = 3;
    run_random(RANDOM_WORDS);

    settle();
    set_config(16'hFFFF, 16'hFFFF);
    gap_odds   = 20;
    stall_odds = 2;
    run_random(RANDOM_WORDS);

    settle();
    set_config(16'($urandom), 16'($urandom));
    gap_odds   = 8;
    stall_odds = 12;
    run_random(RANDOM_WORDS);

    settle();
    set_config(LISTEN_PORT_RST, WANTED_OPCODE_RST);
    gap_odds   = 0;
    stall_odds = 0;
    run_random(RANDOM_WORDS);

    settle();
    $display("Sent %0d frames in %0d words; checked %0d channel results and %0d summaries.",
             frames_sent, sb.words_seen, sb.channels_checked, sb.summaries_checked);
    $display("%0d frames were accepted, over reset, zero, all-ones and random port/opcode.",
             sb.accepted_frames);
    if (sb.mismatches == 0 && sb.dmx_results_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
